/* rtl/ssgr_pkg.sv */
// Package for the sparse sample grid resampler.
// Holds widths, defaults, register indexes and state types; no dependencies.
package ssgr_pkg;

   localparam int DEF_MAX_STEPS = 64;
   localparam int DEF_BATCHES   = 4;
   localparam int DEF_NEURONS   = 256;

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam int VALUE_W = 32;
   localparam int TIME_W  = 48;
   localparam int GRID_W  = 40;
   localparam int FRAC_W  = 8;

   // mul/div operand widths
   localparam int MAG_W = VALUE_W + FRAC_W;     // |diff| * 256
   localparam int DEN_W = TIME_W + 1;           // time gap, origin may be negative
   localparam int QUO_W = MAG_W + 1;
   localparam int POS_W = TIME_W + 2;           // signed time arithmetic

   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_STEP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_STEPS        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILL_MODE        = 2'd3;

   localparam logic [29:0] RST_TICKS_PER_SECOND = 30'd250000000;
   localparam logic [31:0] RST_TICKS_PER_STEP   = 32'd250;
   localparam logic [6:0]  RST_NUM_STEPS        = 7'd64;
   localparam logic        RST_FILL_MODE        = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_SCAN,
      ST_DIV1,
      ST_DIV2,
      ST_EMIT,
      ST_WRITE
   } ssgr_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

/* rtl/ssgr_muldiv.sv */
// Serial multiply-then-divide unit: q = (a * b) / d, r = remainder.
// Shift-add multiply then restoring divide; uses ssgr_pkg.
module ssgr_muldiv import ssgr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] a,
   input  logic [DEN_W-1:0] b,
   input  logic [DEN_W-1:0] d,
   output logic             done,
   output logic [QUO_W-1:0] q,
   output logic [DEN_W-1:0] r
);

   localparam int P_W   = MAG_W + DEN_W;
   localparam int CNT_W = $clog2(P_W);

   md_state_type     state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [MAG_W-1:0] a_ff;
   logic [DEN_W-1:0] b_ff;
   logic [DEN_W-1:0] d_ff;
   logic [P_W-1:0]   p_ff;
   logic [DEN_W-1:0] r_ff;
   logic [QUO_W-1:0] q_ff;
   logic             done_ff;
   logic [DEN_W:0]   rs_c;
   logic             ge_c;

   assign rs_c = {r_ff, p_ff[P_W-1]};
   assign ge_c = rs_c >= {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (start) state_in = MD_MUL;
         MD_MUL:  if (cnt_ff == '0) state_in = MD_DIV;
         MD_DIV:  if (cnt_ff == '0) state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MD_DIV) && (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         MD_IDLE: begin
            a_ff   <= a;
            b_ff   <= b;
            d_ff   <= d;
            p_ff   <= '0;
            cnt_ff <= CNT_W'(DEN_W - 1);
         end
         MD_MUL: begin
            p_ff <= {p_ff[P_W-2:0], 1'b0} + (b_ff[DEN_W-1] ? P_W'(a_ff) : '0);
            b_ff <= {b_ff[DEN_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_ff <= CNT_W'(P_W - 1);
               r_ff   <= '0;
               q_ff   <= '0;
            end else begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
         MD_DIV: begin
            p_ff   <= {p_ff[P_W-2:0], 1'b0};
            r_ff   <= ge_c ? DEN_W'(rs_c - {1'b0, d_ff}) : DEN_W'(rs_c);
            q_ff   <= {q_ff[QUO_W-2:0], ge_c};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign q    = q_ff;
   assign r    = r_ff;

endmodule

/* rtl/ssgr_state_mem.sv */
// Per-channel state memory: seen flag, last value, last time.
// One write port, one registered read port; uses ssgr_pkg.
module ssgr_state_mem import ssgr_pkg::*; #(
   parameter int DEPTH  = DEF_BATCHES * DEF_NEURONS,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 1 + VALUE_W + TIME_W
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/sparse_sample_grid_resampler_core.sv */
// Sparse sample grid resampler top level: sequencer, channel state, output register.
// Uses ssgr_pkg, ssgr_muldiv and ssgr_state_mem.
//
// req channel: one transaction is a sample (tuser=0) or a flush (tuser=1) for one
// batch/neuron channel. rsp channel: one transaction per grid point, tlast on the
// final point caused by a request. csr channel: register writes, always ready;
// write only while the block is idle.
// After reset a clearing pass walks all BATCHES*NEURONS channel memory entries,
// with req_tready low. Each request then passes the READ and PREP lookup states,
// steps over the grid points before the channel's start point, in linear mode runs
// two passes (DIV1, DIV2) through the shared serial multiply/divide unit, emits its
// points, and ends with one state write-back. Points leave through a one-deep output
// register; when the receiver stalls the sequencer waits on that register, and
// req_tready stays low until the request is finished. Out-of-range channels are
// accepted with no output.
module sparse_sample_grid_resampler_core import ssgr_pkg::*; #(
   parameter int MAX_STEPS = DEF_MAX_STEPS,
   parameter int BATCHES   = DEF_BATCHES,
   parameter int NEURONS   = DEF_NEURONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sample_value[31:0], sample_time[79:32], batch_index[81:80], neuron_index[89:82]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // grid_index[5:0], out_batch[7:6], out_neuron[15:8], grid_value[55:16]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int DEPTH  = BATCHES * NEURONS;
   localparam int CH_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int T_W    = $clog2(MAX_STEPS + 1);
   localparam int WORD_W = 1 + VALUE_W + TIME_W;

   ssgr_state_type state_ff, state_in;

   logic [29:0]  tps_ff;
   logic [31:0]  tpstep_ff;
   logic [6:0]   nsteps_ff;
   logic         fmode_ff;

   logic [CH_W-1:0]          clr_cnt_ff;
   logic                     cmd_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [TIME_W-1:0]        time_ff;
   logic [1:0]               b_ff;
   logic [7:0]               n_ff;
   logic [CH_W-1:0]          addr_ff;
   logic signed [VALUE_W-1:0] pv_ff;
   logic signed [POS_W-1:0]  pt_ff;
   logic signed [POS_W-1:0]  pos_ff;
   logic [T_W-1:0]           t_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [QUO_W-1:0]         q_ff;
   logic [DEN_W-1:0]         r_ff;
   logic [QUO_W-1:0]         qs_ff;
   logic [DEN_W-1:0]         rs_ff;

   logic                     rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff;
   logic                     rsp_tlast_ff;

   logic                     req_accept;
   logic [1:0]               req_batch;
   logic [7:0]               req_neuron;
   logic                     chan_ok;
   logic [CH_W-1:0]          idx_c;
   logic [31:0]              step_eff;
   logic [T_W-1:0]           ns_eff;
   logic signed [POS_W-1:0]  time_s;
   logic signed [POS_W-1:0]  pos_next;
   logic [T_W-1:0]           t_next;
   logic                     linear_c;
   logic                     scan_done;
   logic                     before_start;
   logic                     emit_last;
   logic                     out_load;
   logic signed [VALUE_W:0]  diff_c;
   logic [VALUE_W-1:0]       absd_c;
   logic signed [POS_W-1:0]  off_c;
   logic signed [POS_W-1:0]  dnext_c;
   logic signed [41:0]       pv256;
   logic signed [41:0]       val256;
   logic                     round_c;
   logic [QUO_W-1:0]         qr_c;
   logic signed [41:0]       term_c;
   logic signed [41:0]       value_c;
   logic [DEN_W:0]           rsum_c;
   logic                     rge_c;

   logic                     md_start;
   logic                     md_done;
   logic [DEN_W-1:0]         md_b;
   logic [QUO_W-1:0]         md_q;
   logic [DEN_W-1:0]         md_r;

   logic                     mem_we;
   logic [CH_W-1:0]          mem_waddr;
   logic [WORD_W-1:0]        mem_wdata;
   logic [WORD_W-1:0]        mem_rdata;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= RST_TICKS_PER_SECOND;
         tpstep_ff <= RST_TICKS_PER_STEP;
         nsteps_ff <= RST_NUM_STEPS;
         fmode_ff  <= RST_FILL_MODE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TICKS_PER_SECOND: tps_ff    <= csr_data[29:0];
            REG_TICKS_PER_STEP:   tpstep_ff <= csr_data;
            REG_NUM_STEPS:        nsteps_ff <= csr_data[6:0];
            REG_FILL_MODE:        fmode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign step_eff = (tpstep_ff == '0) ? 32'd1 : tpstep_ff;
   assign ns_eff   = (nsteps_ff > 7'(MAX_STEPS)) ? T_W'(MAX_STEPS) : T_W'(nsteps_ff);

   // request decode
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_batch  = req_tdata[81:80];
   assign req_neuron = req_tdata[89:82];
   assign chan_ok    = (int'(req_batch) < BATCHES) && (int'(req_neuron) < NEURONS);
   assign idx_c      = CH_W'(int'(req_batch) * NEURONS + int'(req_neuron));

   // datapath terms
   assign time_s   = signed'(POS_W'(time_ff));
   assign pos_next = pos_ff + signed'(POS_W'(step_eff));
   assign t_next   = t_ff + T_W'(1);
   assign linear_c = !cmd_ff && !fmode_ff;

   assign scan_done    = (t_ff == ns_eff) || (!cmd_ff && (pos_ff >= time_s));
   assign before_start = pos_ff < pt_ff;
   assign emit_last    = (t_next == ns_eff) || (!cmd_ff && (pos_next >= time_s));
   assign out_load     = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   assign diff_c = (VALUE_W+1)'(val_ff) - (VALUE_W+1)'(pv_ff);
   assign absd_c = diff_c[VALUE_W] ? VALUE_W'(-diff_c) : VALUE_W'(diff_c);
   assign off_c  = pos_ff - pt_ff;
   assign dnext_c = time_s - pos_ff;

   assign pv256  = {{2{pv_ff[VALUE_W-1]}}, pv_ff, 8'b0};
   assign val256 = {{2{val_ff[VALUE_W-1]}}, val_ff, 8'b0};

   assign round_c = {r_ff, 1'b0} >= {1'b0, den_ff};
   assign qr_c    = q_ff + QUO_W'(round_c);
   assign term_c  = neg_ff ? -signed'(42'(qr_c)) : signed'(42'(qr_c));

   always_comb begin
      if (cmd_ff) begin
         value_c = pv256;
      end else if (fmode_ff) begin
         value_c = (off_c < dnext_c) ? pv256 : val256;
      end else begin
         value_c = pv256 + term_c;
      end
   end

   assign rsum_c = {1'b0, r_ff} + {1'b0, rs_ff};
   assign rge_c  = rsum_c >= {1'b0, den_ff};

   // shared multiply/divide
   assign md_start = ((state_ff == ST_SCAN) && !scan_done && !before_start && linear_c)
                   || ((state_ff == ST_DIV1) && md_done);
   assign md_b     = (state_ff == ST_SCAN) ? DEN_W'(off_c) : DEN_W'(step_eff);

   ssgr_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (mag_ff),
      .b     (md_b),
      .d     (den_ff),
      .done  (md_done),
      .q     (md_q),
      .r     (md_r)
   );

   // channel state
   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && !cmd_ff);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : {1'b1, val_ff, time_ff};

   ssgr_state_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (CH_W),
      .DATA_W (WORD_W)
   ) u_state_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (idx_c),
      .rdata (mem_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == CH_W'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_accept && chan_ok) state_in = ST_READ;
         ST_READ:  state_in = ST_PREP;
         ST_PREP:  state_in = ST_SCAN;
         ST_SCAN: begin
            priority if (scan_done) state_in = ST_WRITE;
            else if (before_start) state_in = ST_SCAN;
            else if (linear_c)     state_in = ST_DIV1;
            else                   state_in = ST_EMIT;
         end
         ST_DIV1:  if (md_done) state_in = ST_DIV2;
         ST_DIV2:  if (md_done) state_in = ST_EMIT;
         ST_EMIT:  if (out_load && emit_last) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + CH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_tuser;
         val_ff  <= signed'(req_tdata[31:0]);
         time_ff <= req_tdata[79:32];
         b_ff    <= req_batch;
         n_ff    <= req_neuron;
         addr_ff <= idx_c;
      end
      unique case (state_ff)
         ST_READ: begin
            if (mem_rdata[WORD_W-1]) begin
               pv_ff <= signed'(mem_rdata[VALUE_W+TIME_W-1:TIME_W]);
               pt_ff <= signed'(POS_W'(mem_rdata[TIME_W-1:0]));
            end else begin
               pv_ff <= '0;
               pt_ff <= -signed'(POS_W'(tps_ff));
            end
            t_ff   <= '0;
            pos_ff <= '0;
         end
         ST_PREP: begin
            mag_ff <= {absd_c, 8'b0};
            neg_ff <= diff_c[VALUE_W];
            den_ff <= DEN_W'(time_s - pt_ff);
         end
         ST_SCAN: begin
            if (!scan_done && before_start) begin
               t_ff   <= t_next;
               pos_ff <= pos_next;
            end
         end
         ST_DIV1: begin
            if (md_done) begin
               q_ff <= md_q;
               r_ff <= md_r;
            end
         end
         ST_DIV2: begin
            if (md_done) begin
               qs_ff <= md_q;
               rs_ff <= md_r;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               t_ff   <= t_next;
               pos_ff <= pos_next;
               r_ff   <= rge_c ? DEN_W'(rsum_c - {1'b0, den_ff}) : DEN_W'(rsum_c);
               q_ff   <= q_ff + qs_ff + QUO_W'(rge_c);
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= {value_c[GRID_W-1:0], n_ff, b_ff, 6'(t_ff)};
         rsp_tlast_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef ASSERT_OFF
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");

   a_grid_in_range: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (t_ff < ns_eff))
      else $error("grid point beyond grid length");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && linear_c) |-> (r_ff < den_ff))
      else $error("interpolation remainder out of range");

   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_WRITE)))
      else $error("state memory written outside clear or write-back");

   a_md_done_state: assert property (@(posedge clock) disable iff (reset)
      md_done |-> ((state_ff == ST_DIV1) || (state_ff == ST_DIV2)))
      else $error("divider finished while not awaited");
`endif

endmodule
